// ----- rtl/core/channel_to_motor_pwm_duty_core_macros.svh -----
// Assertion macros used by the back end of the channel-to-PWM duty core.
`ifndef CHANNEL_TO_MOTOR_PWM_DUTY_CORE_MACROS_SVH
`define CHANNEL_TO_MOTOR_PWM_DUTY_CORE_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CMPD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmpd assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define CMPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmpd assertion failed");
`else
`define CMPD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CMPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/cmpd_pkg.sv -----
// Types and constants shared by the channel-to-PWM duty core.
package cmpd_pkg;

   // Field and datapath widths.
   localparam int VAL_W        = 32;
   localparam int DIFF_W       = 33;
   localparam int DIVR_W       = 32;
   localparam int PROD_W       = 48;
   localparam int DEND_W       = 47;
   localparam int QUO_W        = 15;
   localparam int PULSE_W      = 15;
   localparam int SCALED_W     = 31;
   localparam int SCALED_SHIFT = 5;
   localparam int RECIP_W      = 27;
   localparam int RECIP_SHIFT  = 36;
   localparam int PRODR_W      = SCALED_W - SCALED_SHIFT + RECIP_W;
   localparam int DUTY_W       = 16;
   localparam int HB_W         = 10;
   localparam int CHAN_W       = 5;
   localparam int OTYPE_W      = 2;
   localparam int ADDR_W       = 4;

   // Output types.
   localparam logic [OTYPE_W-1:0] OTYPE_SERVO   = 2'd0;
   localparam logic [OTYPE_W-1:0] OTYPE_ESC     = 2'd1;
   localparam logic [OTYPE_W-1:0] OTYPE_HBRIDGE = 2'd2;
   localparam logic [OTYPE_W-1:0] OTYPE_NONE    = 2'd3;

   // Request types.
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_HALT   = 1'b1;

   // Register indexes.
   localparam logic [1:0] REG_OUTPUT_TYPE    = 2'd0;
   localparam logic [1:0] REG_SOURCE_CHANNEL = 2'd1;
   localparam logic [1:0] REG_IN_LOW         = 2'd2;
   localparam logic [1:0] REG_IN_HIGH        = 2'd3;

   // Mapping constants.
   localparam logic [DUTY_W-1:0]  NEUTRAL_DUTY = 16'd4915;
   localparam logic [HB_W-1:0]    HB_FULL      = 10'd1023;
   localparam logic [PULSE_W-1:0] PERIOD_US    = 15'd20000;
   // Rounded-up 2^36 / 625, used to divide the scaled pulse by 625.
   localparam logic [RECIP_W-1:0] RECIP_625    = 27'd109951163;

   localparam logic signed [PROD_W-1:0] K_SERVO_MIN  = 48'sd500;
   localparam logic signed [PROD_W-1:0] K_SERVO_SPAN = 48'sd2000;
   localparam logic signed [PROD_W-1:0] K_ESC        = 48'sd1000;
   localparam logic signed [PROD_W-1:0] K_HB         = 48'sd2046;
   localparam logic signed [PROD_W-1:0] K_DEAD       = 48'sd2000;
   localparam logic signed [PROD_W-1:0] K_FWD_EDGE   = 48'sd1001;
   localparam logic signed [PROD_W-1:0] K_REV_EDGE   = 48'sd999;
   localparam logic signed [PROD_W-1:0] K_PERIOD     = 48'sd20000;

   // What the back end does with a command.
   typedef enum logic [1:0] {
      KIND_HALT,
      KIND_ERROR,
      KIND_MAP
   } kind_type;

   // Command passed from the front end to the back end.
   typedef struct packed {
      kind_type                  kind;
      logic [OTYPE_W-1:0]        otype;
      logic signed [DIFF_W-1:0]  n;
      logic signed [DIFF_W-1:0]  d;
   } cmd_type;

   // Control flags that ride along the divider.
   typedef struct packed {
      kind_type           kind;
      logic [OTYPE_W-1:0] otype;
      logic               satlo;
      logic               sathi;
      logic               fwd;
      logic               rev;
      logic               fclamp;
      logic               rclamp;
   } side_type;

endpackage

// ----- rtl/core/channel_to_motor_pwm_duty_core.sv -----
// Top level of the channel-to-PWM duty core: register file and front/back ends.
//
// Usage: control samples enter through a queue-style port (push/full). A sample
// whose channel matches source_channel, or any halt request, yields one result
// of PWM duties on the result port (empty/pop); other samples are dropped.
// The output type register selects servo, ESC or H-bridge mapping; type 3 drops
// every transaction. Registers are written over the APB-style port; the user
// must write them only while idle, which the block itself does not enforce.
// Path: an accepted sample passes a four-entry command queue, three setup
// stages, a fifteen-stage one-bit-per-stage divider, three finishing stages
// and a two-entry result queue.
// Throughput: one sample per cycle while the pipeline is not stalled, set by
// the divider pipeline which takes a new operand every cycle that it advances.
// Reset: the registers return to servo, channel disabled, range 0..1.0, and
// both queues empty.
// Stall: when the receiver stops popping, the result queue fills, the pipeline
// holds, the command queue fills and full rises; no transaction is lost.
module channel_to_motor_pwm_duty_core #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_type,
   input  logic [cmpd_pkg::CHAN_W-1:0]          req_channel_index,
   input  logic signed [cmpd_pkg::VAL_W-1:0]    req_channel_value,
   input  logic                                 pop,
   output logic                                 empty,
   output logic [cmpd_pkg::DUTY_W-1:0]          rsp_duty_primary,
   output logic [cmpd_pkg::HB_W-1:0]            rsp_duty_secondary,
   output logic                                 rsp_range_error,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cmpd_pkg::ADDR_W-1:0]          paddr,
   input  logic [cmpd_pkg::VAL_W-1:0]           pwdata,
   output logic [cmpd_pkg::VAL_W-1:0]           prdata,
   output logic                                 pready
);

   logic [cmpd_pkg::OTYPE_W-1:0]          output_type_ff, output_type_in;
   logic [cmpd_pkg::CHAN_W-1:0]           source_channel_ff, source_channel_in;
   logic signed [cmpd_pkg::VAL_W-1:0]     in_low_ff, in_low_in;
   logic signed [cmpd_pkg::VAL_W-1:0]     in_high_ff, in_high_in;
   logic                                  csr_write;
   logic [1:0]                            csr_index;
   logic                                  cmd_valid;
   logic                                  cmd_pop;
   cmpd_pkg::cmd_type                     cmd;

   // Register file write decode.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[cmpd_pkg::ADDR_W-1:2];

   always_comb begin
      output_type_in    = output_type_ff;
      source_channel_in = source_channel_ff;
      in_low_in         = in_low_ff;
      in_high_in        = in_high_ff;
      if (csr_write) begin
         case (csr_index)
            cmpd_pkg::REG_OUTPUT_TYPE:    output_type_in    = pwdata[cmpd_pkg::OTYPE_W-1:0];
            cmpd_pkg::REG_SOURCE_CHANNEL: source_channel_in = pwdata[cmpd_pkg::CHAN_W-1:0];
            cmpd_pkg::REG_IN_LOW:         in_low_in         = pwdata;
            cmpd_pkg::REG_IN_HIGH:        in_high_in        = pwdata;
            default:                      output_type_in    = output_type_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_type_ff    <= cmpd_pkg::OTYPE_SERVO;
         source_channel_ff <= '0;
         in_low_ff         <= '0;
         in_high_ff        <= 32'sd65536;
      end else begin
         output_type_ff    <= output_type_in;
         source_channel_ff <= source_channel_in;
         in_low_ff         <= in_low_in;
         in_high_ff        <= in_high_in;
      end
   end

   // Register read back.
   always_comb begin
      case (csr_index)
         cmpd_pkg::REG_OUTPUT_TYPE:    prdata = cmpd_pkg::VAL_W'(output_type_ff);
         cmpd_pkg::REG_SOURCE_CHANNEL: prdata = cmpd_pkg::VAL_W'(source_channel_ff);
         cmpd_pkg::REG_IN_LOW:         prdata = in_low_ff;
         cmpd_pkg::REG_IN_HIGH:        prdata = in_high_ff;
         default:                      prdata = '0;
      endcase
   end

   // Front end: filter and classify samples.
   cmpd_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg_output_type    (output_type_ff),
      .cfg_source_channel (source_channel_ff),
      .cfg_in_low         (in_low_ff),
      .cfg_in_high        (in_high_ff),
      .push               (push),
      .full               (full),
      .req_type           (req_type),
      .req_channel_index  (req_channel_index),
      .req_channel_value  (req_channel_value),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop)
   );

   // Back end: compute duties and queue results.
   cmpd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .empty              (empty),
      .pop                (pop),
      .rsp_duty_primary   (rsp_duty_primary),
      .rsp_duty_secondary (rsp_duty_secondary),
      .rsp_range_error    (rsp_range_error)
   );

endmodule

// ----- rtl/core/cmpd_front.sv -----
// Front end: accepts samples, filters and classifies them, and queues commands.
module cmpd_front #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [cmpd_pkg::OTYPE_W-1:0]          cfg_output_type,
   input  logic [cmpd_pkg::CHAN_W-1:0]           cfg_source_channel,
   input  logic signed [cmpd_pkg::VAL_W-1:0]     cfg_in_low,
   input  logic signed [cmpd_pkg::VAL_W-1:0]     cfg_in_high,
   input  logic                                  push,
   output logic                                  full,
   input  logic                                  req_type,
   input  logic [cmpd_pkg::CHAN_W-1:0]           req_channel_index,
   input  logic signed [cmpd_pkg::VAL_W-1:0]     req_channel_value,
   output logic                                  cmd_valid,
   output cmpd_pkg::cmd_type                     cmd,
   input  logic                                  cmd_pop
);

   localparam int CQ_DEPTH = 4;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

   logic                                 accept;
   logic                                 channel_ok;
   logic                                 keep;
   logic                                 wr;
   logic signed [cmpd_pkg::DIFF_W-1:0]   n_val;
   logic signed [cmpd_pkg::DIFF_W-1:0]   d_val;
   cmpd_pkg::cmd_type                    entry;

   cmpd_pkg::cmd_type                    cq_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]                  wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]                  rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]                  count_ff, count_in;

   // Offsets of the sample and of the range from the lower bound.
   assign n_val = cmpd_pkg::DIFF_W'(req_channel_value) - cmpd_pkg::DIFF_W'(cfg_in_low);
   assign d_val = cmpd_pkg::DIFF_W'(cfg_in_high) - cmpd_pkg::DIFF_W'(cfg_in_low);

   // Decide whether the transaction produces a result at all.
   assign accept     = push && !full;
   assign channel_ok = (cfg_source_channel != '0) &&
                       (int'(cfg_source_channel) <= NUM_CHANNELS) &&
                       (req_channel_index == cfg_source_channel);
   assign keep       = (cfg_output_type != cmpd_pkg::OTYPE_NONE) &&
                       ((req_type == cmpd_pkg::REQ_HALT) || channel_ok);
   assign wr         = accept && keep;

   // Classify the command.
   always_comb begin
      entry.otype = cfg_output_type;
      entry.n     = n_val;
      entry.d     = d_val;
      if (req_type == cmpd_pkg::REQ_HALT) begin
         entry.kind = cmpd_pkg::KIND_HALT;
      end else if (d_val == '0) begin
         entry.kind = cmpd_pkg::KIND_ERROR;
      end else begin
         entry.kind = cmpd_pkg::KIND_MAP;
      end
   end

   // Command queue status.
   assign full      = (count_ff == CQ_CNT_W'(CQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = cq_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({wr, cmd_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Queue pointers and storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         cq_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ----- rtl/core/cmpd_div.sv -----
// Pipelined restoring divider: one quotient bit per stage.
module cmpd_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [cmpd_pkg::DEND_W-1:0]    in_dividend,
   input  logic [cmpd_pkg::DIVR_W-1:0]    in_divisor,
   input  cmpd_pkg::side_type             in_side,
   output logic                           out_valid,
   output logic [cmpd_pkg::QUO_W-1:0]     out_quotient,
   output logic                           out_rem_nz,
   output cmpd_pkg::side_type             out_side
);

   localparam int STAGES  = cmpd_pkg::QUO_W;
   localparam int TRIAL_W = cmpd_pkg::DEND_W + 1;

   logic                            valid_ff [STAGES];
   logic                            valid_in [STAGES];
   logic [cmpd_pkg::DEND_W-1:0]     rem_ff   [STAGES];
   logic [cmpd_pkg::DEND_W-1:0]     rem_in   [STAGES];
   logic [cmpd_pkg::QUO_W-1:0]      quo_ff   [STAGES];
   logic [cmpd_pkg::QUO_W-1:0]      quo_in   [STAGES];
   logic [cmpd_pkg::DIVR_W-1:0]     dvsr_ff  [STAGES];
   logic [cmpd_pkg::DIVR_W-1:0]     dvsr_in  [STAGES];
   cmpd_pkg::side_type              side_ff  [STAGES];
   cmpd_pkg::side_type              side_in  [STAGES];

   // Each stage tries to subtract the divisor shifted to its quotient bit.
   always_comb begin
      logic [cmpd_pkg::DEND_W-1:0] rem_src;
      logic [cmpd_pkg::QUO_W-1:0]  quo_src;
      logic [TRIAL_W-1:0]          trial;
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            rem_src     = in_dividend;
            quo_src     = '0;
            dvsr_in[k]  = in_divisor;
            valid_in[k] = in_valid;
            side_in[k]  = in_side;
         end else begin
            rem_src     = rem_ff[k-1];
            quo_src     = quo_ff[k-1];
            dvsr_in[k]  = dvsr_ff[k-1];
            valid_in[k] = valid_ff[k-1];
            side_in[k]  = side_ff[k-1];
         end
         trial = {1'b0, rem_src} - (TRIAL_W'(dvsr_in[k]) << (STAGES - 1 - k));
         if (trial[TRIAL_W-1]) begin
            rem_in[k] = rem_src;
            quo_in[k] = quo_src;
         end else begin
            rem_in[k] = trial[cmpd_pkg::DEND_W-1:0];
            quo_in[k] = quo_src | (cmpd_pkg::QUO_W'(1) << (STAGES - 1 - k));
         end
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dvsr_ff <= dvsr_in;
         side_ff <= side_in;
      end
   end

   assign out_valid    = valid_ff[STAGES-1];
   assign out_quotient = quo_ff[STAGES-1];
   assign out_rem_nz   = (rem_ff[STAGES-1] != '0);
   assign out_side     = side_ff[STAGES-1];

endmodule

// ----- rtl/core/cmpd_back.sv -----
// Back end: maps queued commands to duties through a stalling pipeline and result queue.
`include "channel_to_motor_pwm_duty_core_macros.svh"
module cmpd_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  cmpd_pkg::cmd_type                cmd,
   output logic                             cmd_pop,
   output logic                             empty,
   input  logic                             pop,
   output logic [cmpd_pkg::DUTY_W-1:0]      rsp_duty_primary,
   output logic [cmpd_pkg::HB_W-1:0]        rsp_duty_secondary,
   output logic                             rsp_range_error
);

   localparam int OQ_DEPTH = 2;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   typedef struct packed {
      logic [cmpd_pkg::DUTY_W-1:0] primary;
      logic [cmpd_pkg::HB_W-1:0]   secondary;
      logic                        err;
   } rsp_type;

   logic advance;

   // Stage 1: normalized range.
   logic                                 s1_valid_ff;
   cmpd_pkg::kind_type                   s1_kind_ff;
   logic [cmpd_pkg::OTYPE_W-1:0]         s1_otype_ff;
   logic signed [cmpd_pkg::DIFF_W-1:0]   s1_n_ff, s1_n_in;
   logic [cmpd_pkg::DIVR_W-1:0]          s1_d_ff, s1_d_in;

   // Stage 2: scaled terms.
   logic signed [cmpd_pkg::PROD_W-1:0]   n48, d48;
   logic                                 s2_valid_ff;
   cmpd_pkg::kind_type                   s2_kind_ff;
   logic [cmpd_pkg::OTYPE_W-1:0]         s2_otype_ff;
   logic signed [cmpd_pkg::DIFF_W-1:0]   s2_n_ff;
   logic [cmpd_pkg::DIVR_W-1:0]          s2_d_ff;
   logic signed [cmpd_pkg::PROD_W-1:0]   s2_p_ff, s2_p_in;
   logic signed [cmpd_pkg::PROD_W-1:0]   s2_n2000_ff, s2_d1001_ff, s2_d999_ff, s2_d20000_ff;

   // Stage 3: flags and divider operands.
   logic signed [cmpd_pkg::PROD_W-1:0]   n2_48, d2_48;
   logic                                 s3_valid_ff;
   cmpd_pkg::side_type                   s3_side_ff, s3_side_in;
   logic [cmpd_pkg::DEND_W-1:0]          s3_dend_ff, s3_dend_in;
   logic [cmpd_pkg::DIVR_W-1:0]          s3_dvsr_ff;

   // Divider outputs.
   logic                                 dv_valid;
   logic [cmpd_pkg::QUO_W-1:0]           dv_q;
   logic                                 dv_rem_nz;
   cmpd_pkg::side_type                   dv_side;

   // Finish stages.
   logic [cmpd_pkg::PULSE_W-1:0]         pulse;
   logic [cmpd_pkg::QUO_W-1:0]           ceil_q;
   logic                                 f1_valid_ff;
   cmpd_pkg::kind_type                   f1_kind_ff;
   logic [cmpd_pkg::OTYPE_W-1:0]         f1_otype_ff;
   logic [cmpd_pkg::SCALED_W-1:0]        f1_scaled_ff, f1_scaled_in;
   logic [cmpd_pkg::HB_W-1:0]            f1_fwd_ff, f1_fwd_in;
   logic [cmpd_pkg::HB_W-1:0]            f1_rev_ff, f1_rev_in;
   logic                                 f2_valid_ff;
   cmpd_pkg::kind_type                   f2_kind_ff;
   logic [cmpd_pkg::OTYPE_W-1:0]         f2_otype_ff;
   logic [cmpd_pkg::PRODR_W-1:0]         f2_prod_ff, f2_prod_in;
   logic [cmpd_pkg::HB_W-1:0]            f2_fwd_ff, f2_rev_ff;
   logic [cmpd_pkg::DUTY_W-1:0]          duty16;
   logic                                 f3_valid_ff;
   rsp_type                              f3_rsp_ff, f3_rsp_in;

   // Result queue.
   rsp_type                              oq_ff [OQ_DEPTH];
   rsp_type                              oq_head;
   logic [OQ_PTR_W-1:0]                  oq_wr_ptr_ff, oq_wr_ptr_in;
   logic [OQ_PTR_W-1:0]                  oq_rd_ptr_ff, oq_rd_ptr_in;
   logic [OQ_CNT_W-1:0]                  oq_count_ff, oq_count_in;
   logic                                 oq_full, oq_push, oq_pop;

   // The whole pipeline moves unless a finished result has no room in the queue.
   assign oq_full = (oq_count_ff == OQ_CNT_W'(OQ_DEPTH));
   assign advance = !(f3_valid_ff && oq_full);
   assign cmd_pop = cmd_valid && advance;

   // Stage 1: flip signs so that the range is positive.
   always_comb begin
      if (cmd.d < 0) begin
         s1_n_in = -cmd.n;
         s1_d_in = cmpd_pkg::DIVR_W'(-cmd.d);
      end else begin
         s1_n_in = cmd.n;
         s1_d_in = cmd.d[cmpd_pkg::DIVR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= cmd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff  <= cmd.kind;
         s1_otype_ff <= cmd.otype;
         s1_n_ff     <= s1_n_in;
         s1_d_ff     <= s1_d_in;
      end
   end

   // Stage 2: numerator of the pulse or speed, and the comparison terms.
   assign n48 = cmpd_pkg::PROD_W'(s1_n_ff);
   assign d48 = cmpd_pkg::PROD_W'(s1_d_ff);

   always_comb begin
      case (s1_otype_ff)
         cmpd_pkg::OTYPE_SERVO:   s2_p_in = d48 * cmpd_pkg::K_SERVO_MIN +
                                            n48 * cmpd_pkg::K_SERVO_SPAN;
         cmpd_pkg::OTYPE_ESC:     s2_p_in = (d48 + n48) * cmpd_pkg::K_ESC;
         cmpd_pkg::OTYPE_HBRIDGE: s2_p_in = n48 * cmpd_pkg::K_HB;
         default:                 s2_p_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_kind_ff   <= s1_kind_ff;
         s2_otype_ff  <= s1_otype_ff;
         s2_n_ff      <= s1_n_ff;
         s2_d_ff      <= s1_d_ff;
         s2_p_ff      <= s2_p_in;
         s2_n2000_ff  <= n48 * cmpd_pkg::K_DEAD;
         s2_d1001_ff  <= d48 * cmpd_pkg::K_FWD_EDGE;
         s2_d999_ff   <= d48 * cmpd_pkg::K_REV_EDGE;
         s2_d20000_ff <= d48 * cmpd_pkg::K_PERIOD;
      end
   end

   // Stage 3: saturation, deadband and clamp flags; pick the dividend.
   assign n2_48 = cmpd_pkg::PROD_W'(s2_n_ff);
   assign d2_48 = cmpd_pkg::PROD_W'(s2_d_ff);

   always_comb begin
      s3_side_in.kind   = s2_kind_ff;
      s3_side_in.otype  = s2_otype_ff;
      s3_side_in.satlo  = (s2_p_ff < 0);
      s3_side_in.sathi  = (s2_p_ff >= s2_d20000_ff);
      s3_side_in.fwd    = (s2_n2000_ff > s2_d1001_ff);
      s3_side_in.rev    = (s2_n2000_ff < s2_d999_ff);
      s3_side_in.fclamp = (n2_48 > d2_48);
      s3_side_in.rclamp = (s2_n_ff < 0);
      s3_dend_in        = '0;
      if (s2_kind_ff == cmpd_pkg::KIND_MAP) begin
         if (s2_otype_ff == cmpd_pkg::OTYPE_HBRIDGE) begin
            if (!s3_side_in.fclamp && !s3_side_in.rclamp) begin
               s3_dend_in = s2_p_ff[cmpd_pkg::DEND_W-1:0];
            end
         end else if (!s3_side_in.satlo && !s3_side_in.sathi) begin
            s3_dend_in = s2_p_ff[cmpd_pkg::DEND_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_side_ff <= s3_side_in;
         s3_dend_ff <= s3_dend_in;
         s3_dvsr_ff <= s2_d_ff;
      end
   end

   // Divide the numerator by the range.
   cmpd_div u_div (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (s3_valid_ff),
      .in_dividend  (s3_dend_ff),
      .in_divisor   (s3_dvsr_ff),
      .in_side      (s3_side_ff),
      .out_valid    (dv_valid),
      .out_quotient (dv_q),
      .out_rem_nz   (dv_rem_nz),
      .out_side     (dv_side)
   );

   // Finish stage 1: saturate the pulse and scale it; form the bridge duties.
   always_comb begin
      if (dv_side.satlo) begin
         pulse = '0;
      end else if (dv_side.sathi) begin
         pulse = cmpd_pkg::PERIOD_US;
      end else begin
         pulse = dv_q;
      end
      f1_scaled_in = (cmpd_pkg::SCALED_W'(pulse) << cmpd_pkg::DUTY_W) -
                     cmpd_pkg::SCALED_W'(pulse);
      ceil_q       = dv_q + cmpd_pkg::QUO_W'(dv_rem_nz);
      if (!dv_side.fwd) begin
         f1_fwd_in = '0;
      end else if (dv_side.fclamp) begin
         f1_fwd_in = cmpd_pkg::HB_FULL;
      end else begin
         f1_fwd_in = cmpd_pkg::HB_W'(dv_q - cmpd_pkg::QUO_W'(cmpd_pkg::HB_FULL));
      end
      if (!dv_side.rev) begin
         f1_rev_in = '0;
      end else if (dv_side.rclamp) begin
         f1_rev_in = cmpd_pkg::HB_FULL;
      end else begin
         f1_rev_in = cmpd_pkg::HB_W'(cmpd_pkg::QUO_W'(cmpd_pkg::HB_FULL) - ceil_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_kind_ff   <= dv_side.kind;
         f1_otype_ff  <= dv_side.otype;
         f1_scaled_ff <= f1_scaled_in;
         f1_fwd_ff    <= f1_fwd_in;
         f1_rev_ff    <= f1_rev_in;
      end
   end

   // Finish stage 2: divide the scaled pulse by the period through a reciprocal.
   assign f2_prod_in = f1_scaled_ff[cmpd_pkg::SCALED_W-1:cmpd_pkg::SCALED_SHIFT] *
                       cmpd_pkg::RECIP_625;

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f2_kind_ff  <= f1_kind_ff;
         f2_otype_ff <= f1_otype_ff;
         f2_prod_ff  <= f2_prod_in;
         f2_fwd_ff   <= f1_fwd_ff;
         f2_rev_ff   <= f1_rev_ff;
      end
   end

   // Finish stage 3: pick the result by command kind and output type.
   assign duty16 = f2_prod_ff[cmpd_pkg::RECIP_SHIFT +: cmpd_pkg::DUTY_W];

   always_comb begin
      f3_rsp_in = '0;
      case (f2_kind_ff)
         cmpd_pkg::KIND_HALT: begin
            if (f2_otype_ff != cmpd_pkg::OTYPE_HBRIDGE) begin
               f3_rsp_in.primary = cmpd_pkg::NEUTRAL_DUTY;
            end
         end
         cmpd_pkg::KIND_ERROR: begin
            f3_rsp_in.err = 1'b1;
         end
         cmpd_pkg::KIND_MAP: begin
            if (f2_otype_ff == cmpd_pkg::OTYPE_HBRIDGE) begin
               f3_rsp_in.primary   = cmpd_pkg::DUTY_W'(f2_fwd_ff);
               f3_rsp_in.secondary = f2_rev_ff;
            end else begin
               f3_rsp_in.primary = duty16;
            end
         end
         default: f3_rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_valid_ff <= 1'b0;
      end else if (advance) begin
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f3_rsp_ff <= f3_rsp_in;
      end
   end

   // Result queue: parts the pipeline from the receiver.
   assign oq_push = f3_valid_ff && advance;
   assign oq_pop  = pop && !empty;
   assign empty   = (oq_count_ff == '0);
   assign oq_head = oq_ff[oq_rd_ptr_ff];

   assign rsp_duty_primary   = oq_head.primary;
   assign rsp_duty_secondary = oq_head.secondary;
   assign rsp_range_error    = oq_head.err;

   always_comb begin
      oq_wr_ptr_in = oq_push ? oq_wr_ptr_ff + 1'b1 : oq_wr_ptr_ff;
      oq_rd_ptr_in = oq_pop ? oq_rd_ptr_ff + 1'b1 : oq_rd_ptr_ff;
      case ({oq_push, oq_pop})
         2'b10:   oq_count_in = oq_count_ff + 1'b1;
         2'b01:   oq_count_in = oq_count_ff - 1'b1;
         default: oq_count_in = oq_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ptr_ff <= '0;
         oq_rd_ptr_ff <= '0;
         oq_count_ff  <= '0;
      end else begin
         oq_wr_ptr_ff <= oq_wr_ptr_in;
         oq_rd_ptr_ff <= oq_rd_ptr_in;
         oq_count_ff  <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wr_ptr_ff] <= f3_rsp_ff;
      end
   end

   // A stalled finished result stays in place until the queue has room.
   `CMPD_ASSERT_NEXT(a_stall_holds, clock, reset, f3_valid_ff && !advance, f3_valid_ff && $stable(f3_rsp_ff))
   // The result queue never holds more than its depth.
   `CMPD_ASSERT_SAME(a_oq_bound, clock, reset, 1'b1, oq_count_ff <= OQ_CNT_W'(OQ_DEPTH))
   // A range error always carries zero duties.
   `CMPD_ASSERT_SAME(a_err_zero, clock, reset, !empty && rsp_range_error, rsp_duty_primary == '0 && rsp_duty_secondary == '0)
   // The bridge never drives forward and reverse at once.
   `CMPD_ASSERT_SAME(a_hb_exclusive, clock, reset, f1_valid_ff, f1_fwd_ff == '0 || f1_rev_ff == '0)

endmodule

// ----- tb/channel_to_motor_pwm_duty_core_tb.sv -----
// Self-checking testbench for the channel-to-PWM duty core with a built-in duty predictor.
`timescale 1ns / 100ps

module testbench;
   import cmpd_pkg::*;

   localparam int CHANNELS       = 16;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 20;
   localparam int PHASE_RESULTS  = 95;

   // Mapping constants, in microseconds and percent.
   localparam longint SERVO_MIN_US  = 500;
   localparam longint SERVO_SPAN_US = 2000;
   localparam longint ESC_MIN_US    = 1000;
   localparam longint ESC_SPAN_US   = 1000;
   localparam longint ESC_MID_US    = 1500;
   localparam longint FRAME_US      = 20000;
   localparam longint DUTY16_MAX    = 65535;
   localparam longint BRIDGE_MAX    = 1023;
   localparam longint SPEED_FULL    = 100;
   localparam longint DEADBAND_DIV  = 10;
   localparam longint VAL_MIN       = -64'sd2147483648;
   localparam longint VAL_MAX       = 64'sd2147483647;
   localparam longint ONE_Q16       = 65536;

   typedef struct packed {
      logic [DUTY_W-1:0] primary;
      logic [HB_W-1:0]   secondary;
      logic              range_err;
   } duty_set_t;

   typedef struct {
      logic                     kind;
      logic [CHAN_W-1:0]        chan;
      logic signed [VAL_W-1:0]  val;
   } sample_t;

   logic                     clock;
   logic                     reset             = 1'b1;
   logic                     push              = 1'b0;
   logic                     req_type          = REQ_UPDATE;
   logic [CHAN_W-1:0]        req_channel_index = '0;
   logic signed [VAL_W-1:0]  req_channel_value = '0;
   logic                     pop               = 1'b0;
   logic                     psel              = 1'b0;
   logic                     penable           = 1'b0;
   logic                     pwrite            = 1'b0;
   logic [ADDR_W-1:0]        paddr             = '0;
   logic [VAL_W-1:0]         pwdata            = '0;
   logic                     full;
   logic                     empty;
   logic [DUTY_W-1:0]        rsp_duty_primary;
   logic [HB_W-1:0]          rsp_duty_secondary;
   logic                     rsp_range_error;
   logic [VAL_W-1:0]         prdata;
   logic                     pready;

   // Register copies as the predictor sees them; these start at their reset values.
   logic [OTYPE_W-1:0]       cfg_otype = OTYPE_SERVO;
   logic [CHAN_W-1:0]        cfg_src   = '0;
   logic signed [VAL_W-1:0]  cfg_lo    = '0;
   logic signed [VAL_W-1:0]  cfg_hi    = 32'sd65536;

   duty_set_t pending_duties[$];
   int mismatches       = 0;
   int samples_sent     = 0;
   int results_made     = 0;
   int results_checked  = 0;
   int settings_applied = 0;
   int full_cycles      = 0;
   int quiet_cycles     = 0;
   int pop_stall_pct    = 0;
   int push_gap_pct     = 0;
   int pop_hold_cycles  = 0;

   channel_to_motor_pwm_duty_core #(
      .NUM_CHANNELS(CHANNELS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_type(req_type),
      .req_channel_index(req_channel_index),
      .req_channel_value(req_channel_value),
      .pop(pop),
      .empty(empty),
      .rsp_duty_primary(rsp_duty_primary),
      .rsp_duty_secondary(rsp_duty_secondary),
      .rsp_range_error(rsp_range_error),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Records one mismatch; only the first few are printed.
   function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                         input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
      end
   endfunction

   // Floor division for a positive divisor.
   function automatic longint floor_quot(input longint num, input longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return q;
   endfunction

   // Pulse width in microseconds to 16-bit duty over one frame, saturating.
   function automatic logic [DUTY_W-1:0] pulse_duty(input longint pulse);
      if (pulse < 0) pulse = 0;
      if (pulse > FRAME_US) pulse = FRAME_US;
      return DUTY_W'(pulse * DUTY16_MAX / FRAME_US);
   endfunction

   // Computes the duties for one sample; returns 0 when the block drops the sample.
   function automatic bit predict_duty(input sample_t s, output duty_set_t res);
      longint num, den, spd;
      res = '0;
      if (cfg_otype == OTYPE_NONE) return 1'b0;
      if (s.kind == REQ_HALT) begin
         if (cfg_otype != OTYPE_HBRIDGE) res.primary = pulse_duty(ESC_MID_US);
         return 1'b1;
      end
      if (cfg_src == 0 || cfg_src > CHANNELS || s.chan != cfg_src) return 1'b0;
      num = longint'(s.val) - longint'(cfg_lo);
      den = longint'(cfg_hi) - longint'(cfg_lo);
      if (den == 0) begin
         res.range_err = 1'b1;
         return 1'b1;
      end
      // A reversed range inverts the mapping.
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      case (cfg_otype)
         OTYPE_SERVO: begin
            res.primary = pulse_duty(SERVO_MIN_US + floor_quot(num * SERVO_SPAN_US, den));
         end
         OTYPE_ESC: begin
            res.primary = pulse_duty(ESC_MIN_US + floor_quot(num * ESC_SPAN_US, den));
         end
         default: begin
            // Speed scaled by the range width, clamped to full scale either way.
            spd = 2 * SPEED_FULL * num - SPEED_FULL * den;
            if (spd > SPEED_FULL * den) spd = SPEED_FULL * den;
            if (spd < -SPEED_FULL * den) spd = -SPEED_FULL * den;
            // Speeds within a tenth of a percent of zero fall in the deadband.
            if (DEADBAND_DIV * spd > den) begin
               res.primary = DUTY_W'(spd * BRIDGE_MAX / (SPEED_FULL * den));
            end else if (DEADBAND_DIV * spd < -den) begin
               res.secondary = HB_W'(-spd * BRIDGE_MAX / (SPEED_FULL * den));
            end
         end
      endcase
      return 1'b1;
   endfunction

   function automatic sample_t make_sample(input logic kind, input logic [CHAN_W-1:0] chan,
                                           input logic signed [VAL_W-1:0] val);
      sample_t s;
      s.kind = kind;
      s.chan = chan;
      s.val  = val;
      return s;
   endfunction

   // Channel value biased toward the configured range and the deadband around its middle.
   function automatic logic signed [VAL_W-1:0] pick_value();
      longint lo, hi, span, v;
      int pick;
      lo = cfg_lo;
      hi = cfg_hi;
      span = hi - lo;
      pick = $urandom_range(99);
      if (pick < 55) begin
         v = lo + span * longint'($urandom_range(1000)) / 1000;
      end else if (pick < 75) begin
         v = lo + span / 2 + (longint'($urandom_range(200)) - 100) * span / 50000
             + longint'($urandom_range(4)) - 2;
      end else if (pick < 90) begin
         v = $signed($urandom);
      end else begin
         case ($urandom_range(5))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = lo;
            3: v = hi;
            4: v = lo - 1;
            default: v = hi + 1;
         endcase
      end
      return VAL_W'(v);
   endfunction

   // Mostly samples on the source channel, with halts and stray channels mixed in.
   function automatic sample_t random_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick >= 90) return make_sample(REQ_UPDATE, CHAN_W'($urandom_range(31)), $urandom);
      if (pick >= 78) return make_sample(REQ_HALT, CHAN_W'($urandom_range(31)), $urandom);
      return make_sample(REQ_UPDATE, cfg_src, pick_value());
   endfunction

   function automatic logic [VAL_W-1:0] model_reg(input logic [1:0] idx);
      case (idx)
         REG_OUTPUT_TYPE:    return VAL_W'(cfg_otype);
         REG_SOURCE_CHANNEL: return VAL_W'(cfg_src);
         REG_IN_LOW:         return cfg_lo;
         default:            return cfg_hi;
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] reg_mask(input logic [1:0] idx);
      case (idx)
         REG_OUTPUT_TYPE:    return VAL_W'((1 << OTYPE_W) - 1);
         REG_SOURCE_CHANNEL: return VAL_W'((1 << CHAN_W) - 1);
         default:            return '1;
      endcase
   endfunction

   // One register transaction: a setup phase, an access phase that waits for pready, then the bus idles.
   task automatic csr_access(input bit wr, input logic [1:0] idx,
                             input logic [VAL_W-1:0] wdata, output logic [VAL_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_reg(input logic [1:0] idx);
      logic [VAL_W-1:0] got;
      csr_access(1'b0, idx, '0, got);
      if ((got & reg_mask(idx)) !== (model_reg(idx) & reg_mask(idx))) begin
         flag_mismatch("register readback", model_reg(idx), got);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [VAL_W-1:0] data);
      logic [VAL_W-1:0] unused;
      case (idx)
         REG_OUTPUT_TYPE:    cfg_otype = data[OTYPE_W-1:0];
         REG_SOURCE_CHANNEL: cfg_src   = data[CHAN_W-1:0];
         REG_IN_LOW:         cfg_lo    = data;
         default:            cfg_hi    = data;
      endcase
      csr_access(1'b1, idx, data, unused);
      check_reg(idx);
   endtask

   task automatic apply_config(input logic [OTYPE_W-1:0] otype, input logic [CHAN_W-1:0] src,
                               input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
      write_reg(REG_OUTPUT_TYPE, VAL_W'(otype));
      write_reg(REG_SOURCE_CHANNEL, VAL_W'(src));
      write_reg(REG_IN_LOW, lo);
      write_reg(REG_IN_HIGH, hi);
      settings_applied++;
   endtask

   // Offers one sample until it is accepted, then records the duties it should produce.
   task automatic send_sample(input sample_t s);
      duty_set_t want;
      req_type          <= s.kind;
      req_channel_index <= s.chan;
      req_channel_value <= s.val;
      push              <= 1'b1;
      do @(posedge clock); while (full);
      samples_sent++;
      if (predict_duty(s, want)) begin
         pending_duties.push_back(want);
         results_made++;
      end
   endtask

   task automatic idle_input(input int cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Waits for every pending result, then lets dropped samples clear the pipeline.
   task automatic drain_results();
      push <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_state();
      for (int i = 0; i < 4; i++) check_reg(2'(i));
      send_sample(make_sample(REQ_HALT, 5'd0, 32'sd0));
      send_sample(make_sample(REQ_UPDATE, 5'd1, 32'sd0));
   endtask

   task automatic test_servo_and_esc();
      drain_results();
      apply_config(OTYPE_SERVO, 5'd5, 32'd0, 32'd65536);
      send_sample(make_sample(REQ_UPDATE, 5'd5, 32'h8000_0000));
      send_sample(make_sample(REQ_UPDATE, 5'd5, 32'h7FFF_FFFF));
      send_sample(make_sample(REQ_UPDATE, 5'd5, 32'sd0));
      send_sample(make_sample(REQ_UPDATE, 5'd5, 32'sd65536));
      send_sample(make_sample(REQ_UPDATE, 5'd6, 32'sd32768));
      send_sample(make_sample(REQ_HALT, 5'd31, 32'hFFFF_FFFF));
      drain_results();
      apply_config(OTYPE_ESC, 5'd5, 32'd0, 32'd65536);
      send_sample(make_sample(REQ_UPDATE, 5'd5, 32'sd32768));
      send_sample(make_sample(REQ_UPDATE, 5'd5, 32'h7FFF_FFFF));
      send_sample(make_sample(REQ_HALT, 5'd5, 32'sd0));
   endtask

   // Samples on both edges of the deadband, full scale both ways, and a halt.
   task automatic test_hbridge_deadband();
      drain_results();
      apply_config(OTYPE_HBRIDGE, 5'd16, 32'd0, 32'd65536);
      send_sample(make_sample(REQ_UPDATE, 5'd16, 32'sd32735));
      send_sample(make_sample(REQ_UPDATE, 5'd16, 32'sd32736));
      send_sample(make_sample(REQ_UPDATE, 5'd16, 32'sd32800));
      send_sample(make_sample(REQ_UPDATE, 5'd16, 32'sd32801));
      send_sample(make_sample(REQ_UPDATE, 5'd16, 32'sd0));
      send_sample(make_sample(REQ_UPDATE, 5'd16, 32'sd65536));
      send_sample(make_sample(REQ_UPDATE, 5'd16, 32'h8000_0000));
      send_sample(make_sample(REQ_UPDATE, 5'd16, 32'h7FFF_FFFF));
      send_sample(make_sample(REQ_HALT, 5'd16, 32'sd0));
   endtask

   // Empty range, reversed full-width range, and the output type that drops everything.
   task automatic test_range_corners();
      drain_results();
      apply_config(OTYPE_SERVO, 5'd9, 32'h0001_2345, 32'h0001_2345);
      send_sample(make_sample(REQ_UPDATE, 5'd9, 32'sd100));
      drain_results();
      apply_config(OTYPE_ESC, 5'd9, 32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(make_sample(REQ_UPDATE, 5'd9, 32'sd0));
      send_sample(make_sample(REQ_UPDATE, 5'd9, 32'h8000_0000));
      drain_results();
      apply_config(OTYPE_NONE, 5'd9, 32'd0, 32'd65536);
      send_sample(make_sample(REQ_HALT, 5'd9, 32'sd0));
      send_sample(make_sample(REQ_UPDATE, 5'd9, 32'sd0));
   endtask

   // The receiver holds off while samples keep coming, so the core fills and raises full.
   task automatic test_backpressure();
      drain_results();
      apply_config(OTYPE_SERVO, 5'd3, -32'sd6553600, 32'sd6553600);
      pop_hold_cycles = 300;
      repeat (80) send_sample(make_sample(REQ_UPDATE, 5'd3, pick_value()));
   endtask

   // The sender stops until every result is back, then carries on.
   task automatic test_drain_pause();
      repeat (2) begin
         repeat (25) send_sample(random_sample());
         drain_results();
      end
   endtask

   task automatic random_config();
      logic [OTYPE_W-1:0] otype;
      logic [CHAN_W-1:0]  src;
      longint             lo, hi, k;
      int                 pick;
      otype = ($urandom_range(99) < 8) ? OTYPE_NONE : OTYPE_W'($urandom_range(2));
      src = ($urandom_range(99) < 10) ? CHAN_W'($urandom_range(31))
                                      : CHAN_W'($urandom_range(1, CHANNELS));
      k = $urandom_range(1, 1000);
      pick = $urandom_range(99);
      if (pick < 30) begin
         lo = 0;
         hi = k * ONE_Q16;
      end else if (pick < 50) begin
         lo = -k * ONE_Q16;
         hi = k * ONE_Q16;
      end else if (pick < 62) begin
         lo = k * ONE_Q16;
         hi = -k * ONE_Q16;
      end else if (pick < 80) begin
         lo = $signed($urandom);
         hi = lo + longint'($urandom_range(1, 5000));
      end else if (pick < 90) begin
         lo = $signed($urandom);
         hi = $signed($urandom);
      end else if (pick < 95) begin
         lo = $urandom_range(1) ? VAL_MIN : VAL_MAX;
         hi = (lo == VAL_MIN) ? VAL_MAX : VAL_MIN;
      end else begin
         lo = $signed($urandom);
         hi = lo;
      end
      apply_config(otype, src, VAL_W'(lo), VAL_W'(hi));
   endtask

   // Phases of random traffic, each under a fresh setting and one of the idling patterns.
   task automatic test_random_traffic();
      int  base, sent, cap, mode;
      bit  live;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         random_config();
         mode = phase % 4;
         push_gap_pct  = (mode == 1) ? 45 : (mode == 3) ? 19 : 0;
         pop_stall_pct = (mode == 2) ? 45 : (mode == 3) ? 19 : 0;
         live = (cfg_otype != OTYPE_NONE) && (cfg_src != 0) && (cfg_src <= CHANNELS);
         cap = live ? 3 * PHASE_RESULTS : 40;
         base = results_made;
         sent = 0;
         while (results_made - base < PHASE_RESULTS && sent < cap) begin
            if ($urandom_range(99) < push_gap_pct) idle_input($urandom_range(1, 4));
            send_sample(random_sample());
            sent++;
         end
      end
      push_gap_pct  = 0;
      pop_stall_pct = 0;
   endtask

   // Result side: checks each accepted transaction, then decides whether to pop next cycle.
   always @(posedge clock) begin : result_side
      duty_set_t want;
      if (!reset && pop && !empty) begin
         if (pending_duties.size() == 0) begin
            flag_mismatch("result with nothing pending", '0, 64'(rsp_duty_primary));
         end else begin
            want = pending_duties.pop_front();
            results_checked++;
            if (rsp_duty_primary !== want.primary) begin
               flag_mismatch("duty_primary", 64'(want.primary), 64'(rsp_duty_primary));
            end
            if (rsp_duty_secondary !== want.secondary) begin
               flag_mismatch("duty_secondary", 64'(want.secondary), 64'(rsp_duty_secondary));
            end
            if (rsp_range_error !== want.range_err) begin
               flag_mismatch("range_error", 64'(want.range_err), 64'(rsp_range_error));
            end
         end
      end
      if (pop_hold_cycles > 0) begin
         pop <= 1'b0;
         pop_hold_cycles--;
      end else begin
         pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // Watchdog: ends the run when no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && full) full_cycles <= full_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d results pending.",
                  quiet_cycles, pending_duties.size());
         $display("** channel_to_motor_pwm_duty_core: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_servo_and_esc();
      test_hbridge_deadband();
      test_range_corners();
      test_backpressure();
      test_drain_pause();
      test_random_traffic();
      drain_results();
      $display("Sent %0d samples under %0d register settings; %0d duty results checked.",
               samples_sent, settings_applied, results_checked);
      $display("Input held off by full for %0d cycles; %0d mismatches.",
               full_cycles, mismatches);
      if (mismatches == 0) begin
         $display("** channel_to_motor_pwm_duty_core: PASSED **");
      end else begin
         $display("** channel_to_motor_pwm_duty_core: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/cmpd_pkg.sv
rtl/core/cmpd_front.sv
rtl/core/cmpd_div.sv
rtl/core/cmpd_back.sv
rtl/core/channel_to_motor_pwm_duty_core.sv
tb/channel_to_motor_pwm_duty_core_tb.sv
